// ----- hw/rtl/unsigned_to_ascii_formatter_macros.svh -----
// ----------------------------------------------------------------------------
// unsigned_to_ascii_formatter_macros.svh
// assertion helpers used by the formatter rtl
// ----------------------------------------------------------------------------
`ifndef UNSIGNED_TO_ASCII_FORMATTER_MACROS_SVH
`define UNSIGNED_TO_ASCII_FORMATTER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define UTAF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("utaf same-cycle check failed");

// next-cycle implication, disabled while in reset
`define UTAF_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("utaf next-cycle check failed");

`endif

// ----- hw/rtl/utaf_pkg.sv -----
// ----------------------------------------------------------------------------
// utaf_pkg
// types, constants and helpers for the unsigned to ascii formatter
// ----------------------------------------------------------------------------
package utaf_pkg;

   // input value and digit store geometry
   localparam int VALUE_WIDTH     = 32;
   localparam int NUM_DIGITS      = 10;
   localparam int BCD_WIDTH       = 4 * NUM_DIGITS;
   localparam int DIGIT_CNT_WIDTH = $clog2(NUM_DIGITS + 1);
   localparam int BIT_CNT_WIDTH   = $clog2(VALUE_WIDTH);

   // ascii codes
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_X       = 8'h78;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [3:0] DIGIT_TEN    = 4'd10;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_PREFIX_ZERO,
      ST_PREFIX_X,
      ST_EMIT
   } utaf_state_type;

   // status of the binary to bcd unit
   typedef struct packed {
      logic busy;
      logic done;
   } utaf_bcd_status_type;

   // one digit (0-15) to its ascii character, uppercase letters
   function automatic logic [7:0] digit_to_ascii(input logic [3:0] digit);
      logic [7:0] code;
      if (digit < DIGIT_TEN) begin
         code = CHAR_ZERO + {4'h0, digit};
      end else begin
         code = CHAR_UPPER_A + {4'h0, digit - DIGIT_TEN};
      end
      return code;
   endfunction

endpackage

// ----- hw/rtl/utaf_bcd_unit.sv -----
// ----------------------------------------------------------------------------
// utaf_bcd_unit
// shift-and-add-3 binary to bcd converter, one input bit per cycle
// ----------------------------------------------------------------------------
module utaf_bcd_unit
   import utaf_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [VALUE_WIDTH-1:0]     value,
   output logic [BCD_WIDTH-1:0]       bcd,
   output utaf_bcd_status_type        status
);

   logic [BCD_WIDTH-1:0]     bcd_ff, bcd_in;
   logic [VALUE_WIDTH-1:0]   bin_ff, bin_in;
   logic [BIT_CNT_WIDTH-1:0] count_ff, count_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [BCD_WIDTH-1:0]     adjusted;

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            adjusted[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            adjusted[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   // load on start, then shift one bit of the value in per cycle
   always_comb begin
      bcd_in   = bcd_ff;
      bin_in   = bin_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         bcd_in   = '0;
         bin_in   = value;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         bcd_in   = {adjusted[BCD_WIDTH-2:0], bin_ff[VALUE_WIDTH-1]};
         bin_in   = {bin_ff[VALUE_WIDTH-2:0], 1'b0};
         count_in = count_ff + 1'b1;
         if (count_ff == BIT_CNT_WIDTH'(VALUE_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      bcd_ff <= bcd_in;
      bin_ff <= bin_in;
   end

   assign bcd         = bcd_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ----- hw/rtl/unsigned_to_ascii_formatter.sv -----
// ----------------------------------------------------------------------------
// unsigned_to_ascii_formatter
// formats a 32-bit unsigned value as decimal or 0x-prefixed hex ascii
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: req_value and req_hex_mode, one transaction per number.
//  - rsp channel: one transaction per character, most significant digit
//    first, no leading zeros; rsp_last_char marks the final digit.
//  - hex mode sends '0' and 'x' first, then uppercase digits; zero gives a
//    single '0' digit in both modes.
//  - req_ready is high only while the sequencer is idle: one number at a time.
//  - decimal: after the accept cycle, the shift-and-add-3 unit converts the
//    value, the result is handed over, leading zero digits are dropped one
//    per cycle (up to 9), the skip loop is left, then one character goes out
//    per cycle unless stalled; drops plus characters always total 10.
//  - hex: the value is taken as nibbles directly: after the accept cycle,
//    leading zero nibbles are dropped one per cycle (2 to 9), the skip loop
//    is left, then one character goes out per cycle, prefix first, unless stalled.
//  - the bcd unit takes in one bit of the value per cycle.
//  - a stalled receiver holds the character in the output register and the
//    sequencer waits; the next number may enter while the final character
//    still waits to be taken.
//  - synchronous reset returns the sequencer to idle and drops rsp_valid.
// ----------------------------------------------------------------------------
`include "unsigned_to_ascii_formatter_macros.svh"

module unsigned_to_ascii_formatter
   import utaf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [VALUE_WIDTH-1:0] req_value,
   input  logic                   req_hex_mode,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_ascii_char,
   output logic                   rsp_last_char
);

   utaf_state_type               state_ff, state_in;
   logic [BCD_WIDTH-1:0]         digits_ff, digits_in;
   logic [DIGIT_CNT_WIDTH-1:0]   digits_left_ff, digits_left_in;
   logic                         hex_ff, hex_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [7:0]                   rsp_ascii_char_ff, rsp_ascii_char_in;
   logic                         rsp_last_char_ff, rsp_last_char_in;

   logic                         req_accept;
   logic                         out_free;
   logic                         bcd_start;
   logic [BCD_WIDTH-1:0]         bcd_result;
   utaf_bcd_status_type          bcd_status;
   logic [3:0]                   top_digit;
   logic                         on_last_digit;

   localparam logic [DIGIT_CNT_WIDTH-1:0] DIGITS_FULL = DIGIT_CNT_WIDTH'(NUM_DIGITS);
   localparam logic [DIGIT_CNT_WIDTH-1:0] DIGITS_ONE  = DIGIT_CNT_WIDTH'(1);
   localparam int                         PAD_BITS    = BCD_WIDTH - VALUE_WIDTH;

   assign req_ready     = (state_ff == ST_IDLE);
   assign req_accept    = req_valid && req_ready;
   assign out_free      = !rsp_valid_ff || rsp_ready;
   assign top_digit     = digits_ff[BCD_WIDTH-1 -: 4];
   assign on_last_digit = (digits_left_ff == DIGITS_ONE);

   // binary to bcd unit, started only for decimal requests
   utaf_bcd_unit u_bcd (
      .clock  (clock),
      .reset  (reset),
      .start  (bcd_start),
      .value  (req_value),
      .bcd    (bcd_result),
      .status (bcd_status)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = req_hex_mode ? ST_SKIP : ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            if (bcd_status.done) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (top_digit != 4'h0 || on_last_digit) begin
               state_in = hex_ff ? ST_PREFIX_ZERO : ST_EMIT;
            end
         end
         ST_PREFIX_ZERO: begin
            if (out_free) begin
               state_in = ST_PREFIX_X;
            end
         end
         ST_PREFIX_X: begin
            if (out_free) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free && on_last_digit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and output register loads
   always_comb begin
      digits_in         = digits_ff;
      digits_left_in    = digits_left_ff;
      hex_in            = hex_ff;
      bcd_start         = 1'b0;
      rsp_ascii_char_in = rsp_ascii_char_ff;
      rsp_last_char_in  = rsp_last_char_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               hex_in         = req_hex_mode;
               digits_in      = {{PAD_BITS{1'b0}}, req_value};
               digits_left_in = DIGITS_FULL;
               bcd_start      = !req_hex_mode;
            end
         end
         ST_CONVERT: begin
            if (bcd_status.done) begin
               digits_in      = bcd_result;
               digits_left_in = DIGITS_FULL;
            end
         end
         ST_SKIP: begin
            // drop one leading zero digit per cycle, keep at least one
            if (top_digit == 4'h0 && !on_last_digit) begin
               digits_in      = {digits_ff[BCD_WIDTH-5:0], 4'h0};
               digits_left_in = digits_left_ff - 1'b1;
            end
         end
         ST_PREFIX_ZERO: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_ascii_char_in = CHAR_ZERO;
               rsp_last_char_in  = 1'b0;
            end
         end
         ST_PREFIX_X: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_ascii_char_in = CHAR_X;
               rsp_last_char_in  = 1'b0;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_ascii_char_in = digit_to_ascii(top_digit);
               rsp_last_char_in  = on_last_digit;
               digits_in         = {digits_ff[BCD_WIDTH-5:0], 4'h0};
               digits_left_in    = digits_left_ff - 1'b1;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      digits_ff         <= digits_in;
      digits_left_ff    <= digits_left_in;
      hex_ff            <= hex_in;
      rsp_ascii_char_ff <= rsp_ascii_char_in;
      rsp_last_char_ff  <= rsp_last_char_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ascii_char = rsp_ascii_char_ff;
   assign rsp_last_char  = rsp_last_char_ff;

   // checks
   `UTAF_ASSERT_NXT(a_accept_leaves_idle, clock, reset, req_accept, state_ff != ST_IDLE)
   `UTAF_ASSERT_NXT(a_decimal_starts_bcd, clock, reset,
                    req_accept && !req_hex_mode, bcd_status.busy)
   `UTAF_ASSERT_IMP(a_bcd_done_in_convert, clock, reset, bcd_status.done, state_ff == ST_CONVERT)
   `UTAF_ASSERT_IMP(a_digits_left_nonzero, clock, reset,
                    state_ff == ST_EMIT || state_ff == ST_SKIP, digits_left_ff != '0)
   `UTAF_ASSERT_IMP(a_prefix_only_hex, clock, reset,
                    state_ff == ST_PREFIX_ZERO || state_ff == ST_PREFIX_X, hex_ff)

endmodule
